/* sv/drr_pkg.sv */
// Package for the deficit round robin scheduler: payload structs, status codes,
// and the command record passed from the front end to the back end. No dependencies.
package drr_pkg;

  localparam int unsigned FuncBits   = 1;
  localparam int unsigned FlowIdBits = 4;
  localparam int unsigned LenBits    = 12;
  localparam int unsigned StatusBits = 3;
  localparam int unsigned QuantBits  = 12;

  // Number of flows; one per value of the flow id field.
  localparam int unsigned NumFlows   = 1 << FlowIdBits;

  typedef enum logic [StatusBits-1:0] {
    ST_ENQUEUED  = 3'd0,
    ST_SENT      = 3'd1,
    ST_NO_FLOW   = 3'd2,
    ST_FULL      = 3'd3,
    ST_TOO_LONG  = 3'd4
  } status_t;

  typedef enum logic [FuncBits-1:0] {
    FN_ENQUEUE = 1'b0,
    FN_DEQUEUE = 1'b1
  } func_t;

  typedef struct packed {
    logic [FuncBits-1:0]   func;
    logic [FlowIdBits-1:0] flow_id;
    logic [LenBits-1:0]    pkt_len;
  } in_item_t;

  typedef struct packed {
    logic [StatusBits-1:0] status;
    logic [FlowIdBits-1:0] sent_flow;
    logic [LenBits-1:0]    sent_len;
  } out_item_t;

  // Command handed from the front end to the back end. too_long is resolved
  // in the front end against the quantum that was current at acceptance.
  typedef struct packed {
    logic                  deq;
    logic                  too_long;
    logic [FlowIdBits-1:0] flow_id;
    logic [LenBits-1:0]    pkt_len;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_DONE
  } back_state_t;

endpackage

/* sv/drr_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module drr_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/drr_front.sv */
// Front end: accepts items, checks length against the quantum and pushes a
// command into a two-entry queue. Depends on drr_pkg.
module drr_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  drr_pkg::in_item_t                in_item,
  input  logic [drr_pkg::QuantBits-1:0]    quantum,
  output logic                             cmd_valid,
  output drr_pkg::cmd_t                    cmd,
  input  logic                             cmd_take
);
  import drr_pkg::*;

  cmd_t       q [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;
  cmd_t       new_cmd;

  assign full      = (count == 2'd2);
  assign do_push   = push && !full;
  assign cmd_valid = (count != 2'd0);
  assign do_pop    = cmd_take && cmd_valid;
  assign cmd       = q[rd_ptr];

  always_comb begin
    new_cmd.deq      = (in_item.func == FN_DEQUEUE);
    new_cmd.too_long = {4'd0, in_item.pkt_len} > {{(16-QuantBits){1'b0}}, quantum};
    new_cmd.flow_id  = in_item.flow_id;
    new_cmd.pkt_len  = in_item.pkt_len;
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= new_cmd;
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

/* sv/drr_back.sv */
// Back end: carries out enqueue and dequeue commands against per-flow queue
// state, the active ring and the length memory. Depends on drr_pkg, drr_ram.
module drr_back #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  input  drr_pkg::cmd_t                 cmd,
  output logic                          cmd_take,
  input  logic [drr_pkg::QuantBits-1:0] quantum,
  output logic                          res_valid,
  output drr_pkg::out_item_t            res,
  input  logic                          res_take
);
  import drr_pkg::*;

  localparam int unsigned NUM_FLOWS = NumFlows;
  localparam int unsigned LEN_BITS  = LenBits;
  localparam int unsigned FB = (NUM_FLOWS > 1) ? $clog2(NUM_FLOWS) : 1;
  localparam int unsigned QB = $clog2(QUEUE_DEPTH);
  localparam int unsigned CB = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned RB = $clog2(NUM_FLOWS + 1);
  localparam int unsigned AB = FB + QB;
  localparam int unsigned KB = LEN_BITS + 1;

  logic [QB-1:0]       q_head   [NUM_FLOWS];
  logic [QB-1:0]       q_tail   [NUM_FLOWS];
  logic [CB-1:0]       q_count  [NUM_FLOWS];
  logic [KB-1:0]       credit   [NUM_FLOWS];
  logic [NUM_FLOWS-1:0] active;
  logic [FB-1:0]       ring     [NUM_FLOWS];
  logic [FB-1:0]       ring_head;
  logic [FB-1:0]       ring_tail;
  logic [RB-1:0]       ring_count;

  back_state_t state, state_next;
  cmd_t        cur;
  logic [FB-1:0] dflow;

  logic          ram_we;
  logic [AB-1:0] ram_waddr;
  logic [AB-1:0] ram_raddr;
  logic [LEN_BITS-1:0] ram_rdata;

  out_item_t res_reg;
  logic      res_full;

  logic [FB-1:0] eflow;
  logic [LEN_BITS-1:0] elen;
  logic [KB-1:0] cr_add, cr_sub;
  logic [CB-1:0] left;

  assign eflow = cur.flow_id[FB-1:0];
  assign elen  = cur.pkt_len[LEN_BITS-1:0];
  assign left  = q_count[dflow] - CB'(1);

  always_comb begin
    cr_add = credit[dflow];
    if (credit[dflow] < {1'b0, ram_rdata}) begin
      cr_add = credit[dflow] + KB'(quantum);
    end
    cr_sub = (cr_add >= {1'b0, ram_rdata}) ? cr_add - {1'b0, ram_rdata} : '0;
  end

  // One slot per flow and queue position; the address is {flow, position}.
  drr_ram #(.WIDTH(LEN_BITS), .DEPTH(NUM_FLOWS << QB)) u_len_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (elen),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign res_valid = res_full;
  assign res       = res_reg;
  assign cmd_take  = (state == BK_IDLE) && cmd_valid && !res_full;
  assign ram_waddr = {eflow, q_tail[eflow]};
  assign ram_raddr = {ring[ring_head], q_head[ring[ring_head]]};
  assign ram_we    = (state == BK_READ) && !cur.deq && !cur.too_long
                     && (q_count[eflow] < CB'(QUEUE_DEPTH));

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: if (cmd_take) state_next = BK_READ;
      BK_READ: state_next = (cur.deq && ring_count != '0) ? BK_DONE : BK_IDLE;
      BK_DONE: state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) cur <= cmd;
    if (state == BK_READ) dflow <= ring[ring_head];
    if (rst) begin
      res_full   <= 1'b0;
      active     <= '0;
      ring_head  <= '0;
      ring_tail  <= '0;
      ring_count <= '0;
      for (int i = 0; i < NUM_FLOWS; i++) begin
        q_head[i]  <= '0;
        q_tail[i]  <= '0;
        q_count[i] <= '0;
        credit[i]  <= '0;
      end
    end else begin
      if (res_take && res_full) res_full <= 1'b0;
      case (state)
        BK_READ: begin
          if (!cur.deq) begin
            res_full          <= 1'b1;
            res_reg.sent_flow <= '0;
            res_reg.sent_len  <= '0;
            if (cur.too_long) begin
              res_reg.status <= ST_TOO_LONG;
            end else if (!ram_we) begin
              res_reg.status <= ST_FULL;
            end else begin
              res_reg.status  <= ST_ENQUEUED;
              q_tail[eflow]   <= (q_tail[eflow] == QB'(QUEUE_DEPTH - 1)) ? '0
                                 : q_tail[eflow] + QB'(1);
              q_count[eflow]  <= q_count[eflow] + CB'(1);
              if (!active[eflow]) begin
                active[eflow]    <= 1'b1;
                credit[eflow]    <= '0;
                ring[ring_tail]  <= eflow;
                ring_tail  <= (ring_tail == FB'(NUM_FLOWS - 1)) ? '0 : ring_tail + FB'(1);
                ring_count <= ring_count + RB'(1);
              end
            end
          end else if (ring_count == '0) begin
            res_full          <= 1'b1;
            res_reg.status    <= ST_NO_FLOW;
            res_reg.sent_flow <= '0;
            res_reg.sent_len  <= '0;
          end
        end
        BK_DONE: begin
          res_full          <= 1'b1;
          res_reg.status    <= ST_SENT;
          res_reg.sent_flow <= 4'(dflow);
          res_reg.sent_len  <= 12'(ram_rdata);
          q_head[dflow]  <= (q_head[dflow] == QB'(QUEUE_DEPTH - 1)) ? '0
                            : q_head[dflow] + QB'(1);
          q_count[dflow] <= left;
          if (left == '0) begin
            credit[dflow] <= '0;
            active[dflow] <= 1'b0;
            ring_head  <= (ring_head == FB'(NUM_FLOWS - 1)) ? '0 : ring_head + FB'(1);
            ring_count <= ring_count - RB'(1);
          end else begin
            credit[dflow] <= cr_sub;
            if (cr_sub < {1'b0, ram_rdata}) begin
              // Rotate: the head slot moves to the tail; count is unchanged
              // because the same flow leaves the head and rejoins at the tail.
              ring[ring_tail] <= dflow;
              ring_head <= (ring_head == FB'(NUM_FLOWS - 1)) ? '0 : ring_head + FB'(1);
              ring_tail <= (ring_tail == FB'(NUM_FLOWS - 1)) ? '0 : ring_tail + FB'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

/* sv/deficit_round_robin_scheduler.sv */
// Top level of the deficit round robin scheduler: front end, command queue
// and back end. Depends on drr_pkg, drr_front, drr_back and drr_ram.
//
// Usage. Items enter through a queue-like port: an item transfers on a rising
// edge with push high and full low. func selects enqueue (store pkt_len for
// flow_id) or dequeue (serve the head flow of the active ring). Every item
// yields exactly one result, presented while empty is low and transferred on
// a rising edge with pop high.
// Timing. The front end queues up to two commands. The back end goes through
// BK_READ for each command and on through BK_DONE, after the registered read
// of the length memory, for a dequeue that sends a packet; it takes the next
// command only in BK_IDLE with the result register empty.
// Reset (rst, synchronous) empties every flow queue and the ring, clears all
// credits and sets the quantum to 1500. The length memory is not cleared.
// When the receiver holds pop low the single result register stays full,
// the back end stops, and full rises once the command queue fills.
// The quantum is written with quantum_we/quantum_wdata; the user must do so
// only while the block idles, as the block itself does not enforce this.
module deficit_round_robin_scheduler #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  drr_pkg::in_item_t             in_item,
  output logic                          empty,
  input  logic                          pop,
  output drr_pkg::out_item_t            out_item,
  input  logic                          quantum_we,
  input  logic [drr_pkg::QuantBits-1:0] quantum_wdata
);
  import drr_pkg::*;

  logic [QuantBits-1:0] quantum;
  logic                 cmd_valid;
  logic                 cmd_take;
  cmd_t                 cmd;
  logic                 res_valid;

  // Quantum register, reset to 1500, the standard Ethernet MTU.
  always_ff @(posedge clk) begin
    if (rst) begin
      quantum <= QuantBits'(1500);
    end else if (quantum_we) begin
      quantum <= quantum_wdata;
    end
  end

  drr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .quantum   (quantum),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  drr_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .quantum   (quantum),
    .res_valid (res_valid),
    .res       (out_item),
    .res_take  (pop)
  );

  assign empty = !res_valid;

endmodule
